// ----- src/fbfl_pkg.sv -----
// Shared constants, codes and types of the fixed block free list allocator.
`default_nettype none

package fbfl_pkg;

	// Field widths of the request, response and configuration channels
	localparam int OPCODE_W      = 2;
	localparam int BYTES_W       = 16;
	localparam int INDEX_W       = 10;
	localparam int COUNT_W       = 11;
	localparam int STATUS_W      = 2;
	localparam int BLOCK_BYTES_W = 13;
	localparam int CHUNK_W       = 11;
	localparam int CFG_INDEX_W   = 8;
	localparam int CFG_DATA_W    = 13;

	// Pool geometry
	localparam int MAX_BLOCKS_DEF  = 1024;
	localparam int MIN_BLOCK_BYTES = 8;

	// Saturation limit of the free counter
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Register reset values
	localparam logic [BLOCK_BYTES_W-1:0] BLOCK_BYTES_RST = BLOCK_BYTES_W'(64);
	localparam logic [CHUNK_W-1:0]       CHUNK_BLOCKS_RST = CHUNK_W'(16);

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_BYTES  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_CHUNK_BLOCKS = CFG_INDEX_W'(1);

	typedef enum logic [OPCODE_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_RESET = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_SIZE      = 2'd1,
		STS_ALIGN     = 2'd2,
		STS_EXHAUSTED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_GROW,
		S_RL_RD,
		S_RELINK,
		S_DONE
	} fsm_state_t;

endpackage

`default_nettype wire

// ----- src/fbfl_if.sv -----
// Channel interfaces: request, response and configuration write.
`default_nettype none

interface fbfl_req_if
	import fbfl_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [BYTES_W-1:0]  req_bytes;
	logic [BYTES_W-1:0]  req_align;
	logic [INDEX_W-1:0]  block_index;

	modport source (output valid, opcode, req_bytes, req_align, block_index, input ready);
	modport sink (input valid, opcode, req_bytes, req_align, block_index, output ready);
endinterface

interface fbfl_rsp_if
	import fbfl_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  granted_index;
	logic [COUNT_W-1:0]  free_count;
	logic [COUNT_W-1:0]  total_count;

	modport source (output valid, status, granted_index, free_count, total_count, input ready);
	modport sink (input valid, status, granted_index, free_count, total_count, output ready);
endinterface

interface fbfl_cfg_if
	import fbfl_pkg::*;
();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/fbfl_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered data.
`default_nettype none

module fbfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- src/fixed_block_free_list_allocator.sv -----
// Top level of the fixed block free list allocator.
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+-----------------------------------------------
//  req     | in  | valid/ready        | opcode, req_bytes, req_align, block_index
//  rsp     | out | valid/ready        | status, granted_index, free_count, total_count
//  cfg     | in  | valid/ready (rdy=1)| index (0 block_bytes, 1 chunk_blocks), data
//
//  Steps: free, nop and a rejected alloc finish in the idle state that accepts them;
//  an alloc from a non-empty list does one read of the link RAM. An alloc that grows
//  the pool does one link RAM write per block of the chunk. A pool reset does one
//  chunk RAM read per chunk and one link RAM write per grown block; with nothing
//  grown it finishes in the idle state that accepts it.
//  Reset: asynchronous, clears counters and the list head; neither RAM is cleared,
//  so there is no clearing pass after reset. One request is processed at a time.
//  Stalls: a finished response parks in a hold stage while the output register is
//  full; requests are taken only while no response is parked in the hold stage.
`default_nettype none

module fixed_block_free_list_allocator
	import fbfl_pkg::*;
#(
	parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	fbfl_req_if.sink  req,
	fbfl_rsp_if.source rsp,
	fbfl_cfg_if.sink  cfg
);

	// Index width and count width (count holds MAX_BLOCKS, which also marks list end)
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int NW = (CW > CHUNK_W) ? CW : CHUNK_W;
	localparam int SW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;
	localparam logic [CW-1:0] END_MARK = CW'(MAX_BLOCKS);

	// Architectural state
	fsm_state_t                state_q, state_d;
	logic [CW-1:0]             head_q, head_d;
	logic [COUNT_W-1:0]        free_q, free_d;
	logic [CW-1:0]             grown_q, grown_d;
	logic [BLOCK_BYTES_W-1:0]  block_bytes_q;
	logic [CHUNK_W-1:0]        chunk_q;

	// Walk registers for growth and relink
	logic [CW-1:0] start_q, start_d;
	logic [CW-1:0] end_q, end_d;
	logic [CW-1:0] cur_q, cur_d;

	// Hold stage and output register
	status_t            res_status_q;
	logic [INDEX_W-1:0] res_granted_q;
	logic               out_valid_q;
	status_t            out_status_q;
	logic [INDEX_W-1:0] out_granted_q;
	logic [COUNT_W-1:0] out_free_q;
	logic [COUNT_W-1:0] out_total_q;

	// Memory ports
	logic          link_we, link_re;
	logic [IW-1:0] link_waddr, link_raddr;
	logic [CW-1:0] link_wdata, link_rdata;
	logic          chunk_we, chunk_re;
	logic [IW-1:0] chunk_waddr, chunk_raddr;
	logic [CW-1:0] chunk_wdata, chunk_rdata;

	// Completion and output control
	logic               accept;
	logic               slot_free;
	logic               fin;
	status_t            fin_status;
	logic [INDEX_W-1:0] fin_granted;
	logic               res_load;
	logic               out_load;
	status_t            out_status_d;
	logic [INDEX_W-1:0] out_granted_d;
	logic [COUNT_W-1:0] out_free_d;
	logic [COUNT_W-1:0] out_total_d;

	// Helper arithmetic
	logic [BLOCK_BYTES_W-1:0] eff_bytes;
	logic [CW-1:0]            room;
	logic [CW-1:0]            n_blocks;
	logic                     last_link;
	logic [SW-1:0]            grow_sum;
	logic [COUNT_W-1:0]       grow_sat;
	logic [COUNT_W-1:0]       grown_sat;
	logic                     free_idx_ok;
	logic                     head_empty;

	// next_link: successor of every free block, or the end marker
	fbfl_ram #(.WIDTH(CW), .DEPTH(MAX_BLOCKS)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	// Chunk table: at the first index of each grown chunk, the index past its end
	fbfl_ram #(.WIDTH(CW), .DEPTH(MAX_BLOCKS)) u_chunk_ram (
		.clk   (clk),
		.we    (chunk_we),
		.waddr (chunk_waddr),
		.wdata (chunk_wdata),
		.re    (chunk_re),
		.raddr (chunk_raddr),
		.rdata (chunk_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.granted_index = out_granted_q;
	assign rsp.free_count    = out_free_q;
	assign rsp.total_count   = out_total_q;

	// Effective block size is never below the minimum
	assign eff_bytes = (block_bytes_q < BLOCK_BYTES_W'(MIN_BLOCK_BYTES))
		? BLOCK_BYTES_W'(MIN_BLOCK_BYTES) : block_bytes_q;

	// Growth is cut to the room left in the pool
	assign room     = END_MARK - grown_q;
	assign n_blocks = (NW'(chunk_q) < NW'(room)) ? CW'(chunk_q) : room;

	assign head_empty  = (head_q >= END_MARK);
	assign free_idx_ok = (32'(req.block_index) < 32'(MAX_BLOCKS));
	assign last_link   = ((cur_q + CW'(1)) == end_q);

	// Free count after a growth, saturated
	assign grow_sum = SW'(free_q) + SW'(end_q - start_q);
	assign grow_sat = (grow_sum > SW'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(grow_sum);
	assign grown_sat = (32'(grown_q) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(grown_q);

	// Next state, memory commands and completion
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		free_d      = free_q;
		grown_d     = grown_q;
		start_d     = start_q;
		end_d       = end_q;
		cur_d       = cur_q;
		link_we     = 1'b0;
		link_waddr  = cur_q[IW-1:0];
		link_wdata  = head_q;
		link_re     = 1'b0;
		link_raddr  = head_q[IW-1:0];
		chunk_we    = 1'b0;
		chunk_waddr = grown_q[IW-1:0];
		chunk_wdata = grown_q + n_blocks;
		chunk_re    = 1'b0;
		chunk_raddr = end_q[IW-1:0];
		fin         = 1'b0;
		fin_status  = STS_OK;
		fin_granted = '0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req.opcode)
						OP_ALLOC: begin
							if (req.req_bytes > BYTES_W'(eff_bytes)) begin
								fin        = 1'b1;
								fin_status = STS_SIZE;
							end else if (req.req_align > BYTES_W'(eff_bytes)) begin
								fin        = 1'b1;
								fin_status = STS_ALIGN;
							end else if (!head_empty) begin
								// fetch the successor of the head
								link_re = 1'b1;
								state_d = S_POP;
							end else if (n_blocks == '0) begin
								fin        = 1'b1;
								fin_status = STS_EXHAUSTED;
							end else begin
								// record the chunk and start linking it
								chunk_we = 1'b1;
								start_d  = grown_q;
								cur_d    = grown_q;
								end_d    = grown_q + n_blocks;
								state_d  = S_GROW;
							end
						end
						OP_FREE: begin
							fin = 1'b1;
							if (free_idx_ok) begin
								link_we    = 1'b1;
								link_waddr = IW'(req.block_index);
								link_wdata = head_q;
								head_d     = CW'(req.block_index);
								free_d     = (free_q == COUNT_MAX) ? free_q : free_q + COUNT_W'(1);
							end
						end
						OP_RESET: begin
							head_d = END_MARK;
							if (grown_q == '0) begin
								fin    = 1'b1;
								free_d = '0;
							end else begin
								chunk_re    = 1'b1;
								chunk_raddr = '0;
								start_d     = '0;
								state_d     = S_RL_RD;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				head_d      = link_rdata;
				free_d      = (free_q != '0) ? free_q - COUNT_W'(1) : free_q;
				fin         = 1'b1;
				fin_granted = INDEX_W'(head_q);
			end
			S_RL_RD: begin
				end_d   = chunk_rdata;
				cur_d   = start_q;
				state_d = S_RELINK;
			end
			S_GROW, S_RELINK: begin
				// one link per cycle; the last block of the chunk points at the old head
				link_we    = 1'b1;
				link_waddr = cur_q[IW-1:0];
				link_wdata = last_link ? head_q : cur_q + CW'(1);
				cur_d      = cur_q + CW'(1);
				if (last_link) begin
					if (state_q == S_GROW) begin
						// pop the lowest new index right away
						grown_d     = end_q;
						head_d      = ((start_q + CW'(1)) == end_q) ? head_q : start_q + CW'(1);
						free_d      = grow_sat - COUNT_W'(1);
						fin         = 1'b1;
						fin_granted = INDEX_W'(start_q);
					end else begin
						head_d = start_q;
						if (end_q == grown_q) begin
							free_d = grown_sat;
							fin    = 1'b1;
						end else begin
							start_d  = end_q;
							chunk_re = 1'b1;
							state_d  = S_RL_RD;
						end
					end
				end
			end
			S_DONE: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Retire: straight into the output register, or park in the hold stage
		res_load = 1'b0;
		if (fin) begin
			if (slot_free) begin
				state_d = S_IDLE;
			end else begin
				state_d  = S_DONE;
				res_load = 1'b1;
			end
		end
	end

	// Output register load
	always_comb begin
		out_load      = 1'b0;
		out_status_d  = fin_status;
		out_granted_d = fin_granted;
		out_free_d    = free_d;
		out_total_d   = COUNT_W'(grown_d);
		if (fin && slot_free) begin
			out_load = 1'b1;
		end else if (state_q == S_DONE && slot_free) begin
			out_load      = 1'b1;
			out_status_d  = res_status_q;
			out_granted_d = res_granted_q;
			out_free_d    = free_q;
			out_total_d   = COUNT_W'(grown_q);
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= END_MARK;
			free_q        <= '0;
			grown_q       <= '0;
			block_bytes_q <= BLOCK_BYTES_RST;
			chunk_q       <= CHUNK_BLOCKS_RST;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			free_q  <= free_d;
			grown_q <= grown_d;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_BLOCK_BYTES:  block_bytes_q <= cfg.data[BLOCK_BYTES_W-1:0];
					REG_CHUNK_BLOCKS: chunk_q       <= cfg.data[CHUNK_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		start_q <= start_d;
		end_q   <= end_d;
		cur_q   <= cur_d;
		if (res_load) begin
			res_status_q  <= fin_status;
			res_granted_q <= fin_granted;
		end
		if (out_load) begin
			out_status_q  <= out_status_d;
			out_granted_q <= out_granted_d;
			out_free_q    <= out_free_d;
			out_total_q   <= out_total_d;
		end
	end

endmodule

`default_nettype wire

// ----- src/fbfl_chk.sv -----
// Port-level checker of the allocator and its bind to the top level.
`default_nettype none

module fbfl_chk
	import fbfl_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_valid,
	input wire logic                req_ready,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire logic [STATUS_W-1:0] status,
	input wire logic [INDEX_W-1:0]  granted_index,
	input wire logic [COUNT_W-1:0]  free_count,
	input wire logic [COUNT_W-1:0]  total_count
);

	logic [2:0] pend_q;
	logic       req_fire;
	logic       rsp_fire;

	assign req_fire = req_valid && req_ready;
	assign rsp_fire = rsp_valid && rsp_ready;

	// Requests taken minus responses delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(req_fire) - 3'(rsp_fire);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(granted_index)
			&& $stable(free_count) && $stable(total_count))
		else $error("response changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 3'd0)
		else $error("response without a pending request");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("more than two requests in flight");

	a_grant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != STS_OK |-> granted_index == '0)
		else $error("failed request reports a granted index");

endmodule

bind fixed_block_free_list_allocator fbfl_chk u_fbfl_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.granted_index (rsp.granted_index),
	.free_count    (rsp.free_count),
	.total_count   (rsp.total_count)
);

`default_nettype wire
